// ----- hw/rtl/atl_pkg.sv -----
// Shared types, character constants and codes for the assembly token lexer.
// Depends on nothing; every lexer module imports it.
package atl_pkg;

   // Default sizes handed to the top-level parameters.
   localparam int LINE_BITS_DEF   = 16;
   localparam int QUEUE_DEPTH_DEF = 4;

   // Source characters that the lexer recognizes.
   localparam logic [7:0] CH_SPACE      = 8'h20;
   localparam logic [7:0] CH_TAB        = 8'h09;
   localparam logic [7:0] CH_NEWLINE    = 8'h0A;
   localparam logic [7:0] CH_CR         = 8'h0D;
   localparam logic [7:0] CH_BELL       = 8'h07;
   localparam logic [7:0] CH_NUL        = 8'h00;
   localparam logic [7:0] CH_COMMA      = 8'h2C;
   localparam logic [7:0] CH_COLON      = 8'h3A;
   localparam logic [7:0] CH_LBRACKET   = 8'h5B;
   localparam logic [7:0] CH_RBRACKET   = 8'h5D;
   localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CH_HYPHEN     = 8'h2D;
   localparam logic [7:0] CH_QUOTE      = 8'h22;
   localparam logic [7:0] CH_BACKSLASH  = 8'h5C;
   localparam logic [7:0] CH_DIGIT_0    = 8'h30;
   localparam logic [7:0] CH_DIGIT_9    = 8'h39;
   localparam logic [7:0] CH_UPPER_A    = 8'h41;
   localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
   localparam logic [7:0] CH_LOWER_A    = 8'h61;
   localparam logic [7:0] CH_LOWER_Z    = 8'h7A;
   localparam logic [7:0] CH_LOWER_N    = 8'h6E;
   localparam logic [7:0] CH_LOWER_T    = 8'h74;
   localparam logic [7:0] CH_LOWER_R    = 8'h72;

   // Token kinds reported on the response channel.
   localparam logic [2:0] KIND_NONE     = 3'd0;
   localparam logic [2:0] KIND_COMMA    = 3'd1;
   localparam logic [2:0] KIND_COLON    = 3'd2;
   localparam logic [2:0] KIND_LBRACKET = 3'd3;
   localparam logic [2:0] KIND_RBRACKET = 3'd4;
   localparam logic [2:0] KIND_NUMBER   = 3'd5;
   localparam logic [2:0] KIND_IDENT    = 3'd6;
   localparam logic [2:0] KIND_STRING   = 3'd7;

   // Sticky error codes.
   localparam logic [1:0] ERR_NONE       = 2'd0;
   localparam logic [1:0] ERR_UNEXPECTED = 2'd1;
   localparam logic [1:0] ERR_ESCAPE     = 2'd2;

   // Character classes produced by the front end.
   typedef enum logic [3:0] {
      CLS_SPACE,
      CLS_NEWLINE,
      CLS_COMMA,
      CLS_COLON,
      CLS_LBRACKET,
      CLS_RBRACKET,
      CLS_DIGIT,
      CLS_LETTER,
      CLS_HYPHEN,
      CLS_QUOTE,
      CLS_BACKSLASH,
      CLS_OTHER
   } char_class_type;

   // Lexer mode between requests.
   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_NUM,
      MODE_IDENT,
      MODE_STR
   } lex_mode_type;

   // One classified byte as it travels through the queue.
   typedef struct packed {
      logic [7:0]     char_byte;
      logic           last_byte;
      char_class_type char_class;
      logic           esc_ok;
      logic [7:0]     esc_byte;
   } lex_item_type;

endpackage

// ----- hw/rtl/atl_front.sv -----
// Front end of the lexer: classifies each request byte and translates escapes.
// Depends on atl_pkg.
module atl_front
   import atl_pkg::*;
(
   input  logic [7:0]   req_char_byte,
   input  logic         req_last_byte,
   output lex_item_type item
);

   char_class_type cls;
   logic           esc_ok;
   logic [7:0]     esc_byte;

   // Character class of the byte.
   always_comb begin
      case (req_char_byte) inside
         CH_SPACE, CH_TAB:                      cls = CLS_SPACE;
         CH_NEWLINE:                            cls = CLS_NEWLINE;
         CH_COMMA:                              cls = CLS_COMMA;
         CH_COLON:                              cls = CLS_COLON;
         CH_LBRACKET:                           cls = CLS_LBRACKET;
         CH_RBRACKET:                           cls = CLS_RBRACKET;
         [CH_DIGIT_0:CH_DIGIT_9]:               cls = CLS_DIGIT;
         [CH_UPPER_A:CH_UPPER_Z],
         [CH_LOWER_A:CH_LOWER_Z], CH_UNDERSCORE: cls = CLS_LETTER;
         CH_HYPHEN:                             cls = CLS_HYPHEN;
         CH_QUOTE:                              cls = CLS_QUOTE;
         CH_BACKSLASH:                          cls = CLS_BACKSLASH;
         default:                               cls = CLS_OTHER;
      endcase
   end

   // Translation of the byte when it follows a backslash in a string.
   always_comb begin
      esc_ok = 1'b1;
      case (req_char_byte)
         CH_LOWER_N:   esc_byte = CH_NEWLINE;
         CH_LOWER_T:   esc_byte = CH_TAB;
         CH_LOWER_R:   esc_byte = CH_CR;
         CH_LOWER_A:   esc_byte = CH_BELL;
         CH_DIGIT_0:   esc_byte = CH_NUL;
         CH_QUOTE:     esc_byte = CH_QUOTE;
         CH_BACKSLASH: esc_byte = CH_BACKSLASH;
         default: begin
            esc_ok   = 1'b0;
            esc_byte = CH_NUL;
         end
      endcase
   end

   // Pack the classified request.
   always_comb begin
      item.char_byte  = req_char_byte;
      item.last_byte  = req_last_byte;
      item.char_class = cls;
      item.esc_ok     = esc_ok;
      item.esc_byte   = esc_byte;
   end

endmodule

// ----- hw/rtl/atl_queue.sv -----
// Short queue of classified requests between the lexer front and back ends.
// Depends on atl_pkg.
module atl_queue
   import atl_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push_valid,
   input  lex_item_type push_item,
   output logic         full,
   input  logic         pop,
   output logic         head_valid,
   output lex_item_type head_item
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   lex_item_type     mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign push       = push_valid && !full;
   assign head_valid = (count_ff != '0);
   assign head_item  = mem_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- hw/rtl/atl_back.sv -----
// Back end of the lexer: token state machine, line counter, sticky error and
// the registered response stage. Depends on atl_pkg.
module atl_back
   import atl_pkg::*;
#(
   parameter int LINE_BITS = LINE_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         head_valid,
   input  lex_item_type head_item,
   output logic         pop,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [2:0]   rsp_token_kind,
   output logic         rsp_token_start,
   output logic         rsp_token_end,
   output logic         rsp_prev_closed,
   output logic         rsp_text_valid,
   output logic [7:0]   rsp_text_byte,
   output logic [15:0]  rsp_line_number,
   output logic [1:0]   rsp_error_code,
   output logic         rsp_text_done
);

   lex_mode_type         mode_ff, mode_in;
   logic                 pend_ff, pend_in;
   logic [LINE_BITS-1:0] line_ff, line_in, line_upd;
   logic [1:0]           err_ff, err_in, err_upd;

   logic                 take;
   char_class_type       cls;
   logic                 active, open_break, idle_path, idle_err, esc_err, new_err;
   logic [31:0]          line_wide;

   logic [2:0]           kind;
   logic                 tok_start, tok_end, closed, tv, stay_open;
   logic [7:0]           tb;

   logic                 rsp_valid_ff;
   logic [2:0]           kind_ff;
   logic                 start_ff, end_ff, closed_ff, tv_ff, done_ff;
   logic [7:0]           tb_ff;
   logic [15:0]          line_out_ff;
   logic [1:0]           err_out_ff;

   // A queued request moves on when the response register is free or drains.
   assign take = head_valid && (!rsp_valid_ff || !rsp_stall);
   assign pop  = take;
   assign cls  = head_item.char_class;

   // Decode of the head request against the current mode.
   always_comb begin
      active     = (err_ff == ERR_NONE);
      open_break = ((mode_ff == MODE_NUM) && (cls != CLS_DIGIT)) ||
                   ((mode_ff == MODE_IDENT) && !(cls == CLS_LETTER ||
                     cls == CLS_DIGIT || cls == CLS_HYPHEN));
      idle_path  = (mode_ff == MODE_IDLE) || open_break;
      idle_err   = idle_path && (cls == CLS_HYPHEN || cls == CLS_BACKSLASH ||
                                 cls == CLS_OTHER);
      esc_err    = (mode_ff == MODE_STR) && pend_ff && !head_item.esc_ok;
      new_err    = active && (idle_err || esc_err);
   end

   // Line count and error code as they stand after this request.
   always_comb begin
      line_upd = line_ff;
      err_upd  = err_ff;
      if (active && idle_path && (cls == CLS_NEWLINE) && (line_ff != '1)) begin
         line_upd = line_ff + 1'b1;
      end
      if (new_err) begin
         err_upd = idle_err ? ERR_UNEXPECTED : ERR_ESCAPE;
      end
   end

   // Next state of the lexer.
   always_comb begin
      mode_in = mode_ff;
      pend_in = pend_ff;
      line_in = line_ff;
      err_in  = err_ff;
      if (take) begin
         if (head_item.last_byte) begin
            mode_in = MODE_IDLE;
            pend_in = 1'b0;
            line_in = '0;
            err_in  = ERR_NONE;
         end else begin
            line_in = line_upd;
            err_in  = err_upd;
            if (new_err) begin
               mode_in = MODE_IDLE;
               pend_in = 1'b0;
            end else if (active) begin
               if (idle_path) begin
                  case (cls)
                     CLS_DIGIT:  mode_in = MODE_NUM;
                     CLS_LETTER: mode_in = MODE_IDENT;
                     CLS_QUOTE: begin
                        mode_in = MODE_STR;
                        pend_in = 1'b0;
                     end
                     default:    mode_in = MODE_IDLE;
                  endcase
               end else if (mode_ff == MODE_STR) begin
                  if (pend_ff) begin
                     pend_in = 1'b0;
                  end else if (cls == CLS_BACKSLASH) begin
                     pend_in = 1'b1;
                  end else if (cls == CLS_QUOTE) begin
                     mode_in = MODE_IDLE;
                  end
               end
            end
         end
      end
   end

   // Response fields for the head request.
   always_comb begin
      kind      = KIND_NONE;
      tok_start = 1'b0;
      tok_end   = 1'b0;
      closed    = 1'b0;
      tv        = 1'b0;
      tb        = CH_NUL;
      stay_open = 1'b0;
      if (active) begin
         closed = open_break;
         if (!new_err) begin
            if (idle_path) begin
               tb        = head_item.char_byte;
               tv        = 1'b1;
               tok_start = 1'b1;
               case (cls)
                  CLS_COMMA: begin
                     kind    = KIND_COMMA;
                     tok_end = 1'b1;
                  end
                  CLS_COLON: begin
                     kind    = KIND_COLON;
                     tok_end = 1'b1;
                  end
                  CLS_LBRACKET: begin
                     kind    = KIND_LBRACKET;
                     tok_end = 1'b1;
                  end
                  CLS_RBRACKET: begin
                     kind    = KIND_RBRACKET;
                     tok_end = 1'b1;
                  end
                  CLS_DIGIT: begin
                     kind      = KIND_NUMBER;
                     stay_open = 1'b1;
                  end
                  CLS_LETTER: begin
                     kind      = KIND_IDENT;
                     stay_open = 1'b1;
                  end
                  CLS_QUOTE: begin
                     kind      = KIND_STRING;
                     stay_open = 1'b1;
                  end
                  default: begin
                     // Whitespace and newlines between tokens emit nothing.
                     tb        = CH_NUL;
                     tv        = 1'b0;
                     tok_start = 1'b0;
                  end
               endcase
            end else begin
               case (mode_ff)
                  MODE_NUM: begin
                     kind      = KIND_NUMBER;
                     tv        = 1'b1;
                     tb        = head_item.char_byte;
                     stay_open = 1'b1;
                  end
                  MODE_IDENT: begin
                     kind      = KIND_IDENT;
                     tv        = 1'b1;
                     tb        = head_item.char_byte;
                     stay_open = 1'b1;
                  end
                  MODE_STR: begin
                     kind = KIND_STRING;
                     if (pend_ff) begin
                        tv        = 1'b1;
                        tb        = head_item.esc_byte;
                        stay_open = 1'b1;
                     end else if (cls == CLS_BACKSLASH) begin
                        // The escaping backslash itself carries no text.
                        stay_open = 1'b1;
                     end else if (cls == CLS_QUOTE) begin
                        tv      = 1'b1;
                        tb      = head_item.char_byte;
                        tok_end = 1'b1;
                     end else begin
                        tv        = 1'b1;
                        tb        = head_item.char_byte;
                        stay_open = 1'b1;
                     end
                  end
                  default: begin
                     kind = KIND_NONE;
                  end
               endcase
            end
            // A token still open at the end of the text closes on its last byte.
            tok_end = tok_end || (head_item.last_byte && stay_open);
         end
      end
   end

   assign line_wide = 32'(line_upd);

   // Lexer state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         pend_ff <= 1'b0;
         line_ff <= '0;
         err_ff  <= ERR_NONE;
      end else begin
         mode_ff <= mode_in;
         pend_ff <= pend_in;
         line_ff <= line_in;
         err_ff  <= err_in;
      end
   end

   // Response valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Response payload register.
   always_ff @(posedge clock) begin
      if (take) begin
         kind_ff     <= kind;
         start_ff    <= tok_start;
         end_ff      <= tok_end;
         closed_ff   <= closed;
         tv_ff       <= tv;
         tb_ff       <= tb;
         line_out_ff <= line_wide[15:0];
         err_out_ff  <= err_upd;
         done_ff     <= head_item.last_byte;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_token_kind  = kind_ff;
   assign rsp_token_start = start_ff;
   assign rsp_token_end   = end_ff;
   assign rsp_prev_closed = closed_ff;
   assign rsp_text_valid  = tv_ff;
   assign rsp_text_byte   = tb_ff;
   assign rsp_line_number = line_out_ff;
   assign rsp_error_code  = err_out_ff;
   assign rsp_text_done   = done_ff;

endmodule

// ----- hw/rtl/assembly_token_lexer.sv -----
// Assembly token lexer, one response per source byte.
// A request is queued, then taken into the registered response stage.
// Throughput: one byte per clock unless the response stalls, set by the token
// state machine in the back end; a QUEUE_DEPTH-entry queue decouples the ends.
// Reset (synchronous) empties the queue, drops any response and returns the
// lexer to idle with line count and error cleared.
module assembly_token_lexer
   import atl_pkg::*;
#(
   parameter int LINE_BITS   = LINE_BITS_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_token_kind,
   output logic        rsp_token_start,
   output logic        rsp_token_end,
   output logic        rsp_prev_closed,
   output logic        rsp_text_valid,
   output logic [7:0]  rsp_text_byte,
   output logic [15:0] rsp_line_number,
   output logic [1:0]  rsp_error_code,
   output logic        rsp_text_done
);

   lex_item_type front_item;
   lex_item_type head_item;
   logic         head_valid;
   logic         pop;

   // Classify the incoming request.
   atl_front u_front (
      .req_char_byte (req_char_byte),
      .req_last_byte (req_last_byte),
      .item          (front_item)
   );

   // Queue between classification and token tracking.
   atl_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_item  (front_item),
      .full       (req_stall),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   // Token state machine and response register.
   atl_back #(
      .LINE_BITS (LINE_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head_item       (head_item),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_token_kind  (rsp_token_kind),
      .rsp_token_start (rsp_token_start),
      .rsp_token_end   (rsp_token_end),
      .rsp_prev_closed (rsp_prev_closed),
      .rsp_text_valid  (rsp_text_valid),
      .rsp_text_byte   (rsp_text_byte),
      .rsp_line_number (rsp_line_number),
      .rsp_error_code  (rsp_error_code),
      .rsp_text_done   (rsp_text_done)
   );

endmodule

// ----- hw/rtl/atl_checker.sv -----
// Port-level checks for the assembly token lexer, bound to the top level.
// Depends on atl_pkg.
module atl_checker
   import atl_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [2:0]  rsp_token_kind,
   input logic        rsp_token_start,
   input logic        rsp_text_valid,
   input logic [7:0]  rsp_text_byte,
   input logic [1:0]  rsp_error_code
);

   // A stalled response stays offered with the same text.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_text_byte))
      else $error("stalled response changed");

   // Text bytes are zero when no text is carried.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_text_valid |-> rsp_text_byte == CH_NUL)
      else $error("text byte without text valid");

   // Once an error is flagged, no token start, text or kind is reported.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_error_code != ERR_NONE) |->
         !rsp_token_start && !rsp_text_valid && (rsp_token_kind == KIND_NONE))
      else $error("token activity under error");

   // A new token always carries its first character and a kind.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_token_start |->
         rsp_text_valid && (rsp_token_kind != KIND_NONE))
      else $error("token start without text");

endmodule

bind assembly_token_lexer atl_checker u_atl_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_token_kind  (rsp_token_kind),
   .rsp_token_start (rsp_token_start),
   .rsp_text_valid  (rsp_text_valid),
   .rsp_text_byte   (rsp_text_byte),
   .rsp_error_code  (rsp_error_code)
);

// ----- dv/lexer_checker.sv -----
// Checker for the assembly token lexer: watches both channels and predicts each response.
// Uses the token kinds, character constants and lexer modes of atl_pkg.
// Reports mismatches, responses still owed and the count of requests that were lexed.
module lexer_checker
   import atl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_char_byte,
   input  logic        req_last_byte,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [2:0]  rsp_token_kind,
   input  logic        rsp_token_start,
   input  logic        rsp_token_end,
   input  logic        rsp_prev_closed,
   input  logic        rsp_text_valid,
   input  logic [7:0]  rsp_text_byte,
   input  logic [15:0] rsp_line_number,
   input  logic [1:0]  rsp_error_code,
   input  logic        rsp_text_done,
   output int          mismatch_count,
   output int          pending_count,
   output int          lexed_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int REPORT_LIMIT = 10;

   // One response of the lexer, in port order.
   typedef struct packed {
      logic [2:0]  kind;
      logic        start;
      logic        tok_end;
      logic        closed;
      logic        text_valid;
      logic [7:0]  text_byte;
      logic [15:0] line;
      logic [1:0]  err;
      logic        done;
   } lex_token_type;

   // Predicted lexer state.
   lex_mode_type mode_r;
   logic         escape_r;
   logic [15:0]  lines_r;
   logic [1:0]   error_r;

   // Responses predicted but not yet seen, oldest first.
   lex_token_type token_q[$];

   function automatic logic dec_digit(input logic [7:0] c);
      return c >= CH_DIGIT_0 && c <= CH_DIGIT_9;
   endfunction

   function automatic logic alpha_char(input logic [7:0] c);
      return (c >= CH_LOWER_A && c <= CH_LOWER_Z) || (c >= CH_UPPER_A && c <= CH_UPPER_Z);
   endfunction

   function automatic string describe(input lex_token_type t);
      return $sformatf("kind=%0d start=%0b end=%0b closed=%0b text=%0b/%02h line=%0d err=%0d done=%0b",
                       t.kind, t.start, t.tok_end, t.closed, t.text_valid, t.text_byte,
                       t.line, t.err, t.done);
   endfunction

   // Advances the predicted state by one source byte and returns its response.
   function automatic lex_token_type lex_byte(input logic [7:0] c, input logic last);
      lex_token_type r;
      logic          scan_idle;
      logic          esc_known;
      logic [7:0]    esc_char;
      r = '0;
      scan_idle = 1'b0;
      esc_known = 1'b1;
      esc_char = CH_NUL;
      if (error_r == ERR_NONE) begin
         case (mode_r)
            MODE_NUM: begin
               if (dec_digit(c)) begin
                  r.kind = KIND_NUMBER;
                  r.text_valid = 1'b1;
                  r.text_byte = c;
               end else begin
                  r.closed = 1'b1;
                  mode_r = MODE_IDLE;
                  scan_idle = 1'b1;
               end
            end
            MODE_IDENT: begin
               if (alpha_char(c) || dec_digit(c) || c == CH_UNDERSCORE || c == CH_HYPHEN) begin
                  r.kind = KIND_IDENT;
                  r.text_valid = 1'b1;
                  r.text_byte = c;
               end else begin
                  r.closed = 1'b1;
                  mode_r = MODE_IDLE;
                  scan_idle = 1'b1;
               end
            end
            MODE_STR: begin
               r.kind = KIND_STRING;
               if (escape_r) begin
                  // The byte after a backslash is translated or is an error.
                  escape_r = 1'b0;
                  case (c)
                     CH_LOWER_N:   esc_char = CH_NEWLINE;
                     CH_LOWER_T:   esc_char = CH_TAB;
                     CH_LOWER_R:   esc_char = CH_CR;
                     CH_LOWER_A:   esc_char = CH_BELL;
                     CH_DIGIT_0:   esc_char = CH_NUL;
                     CH_QUOTE:     esc_char = CH_QUOTE;
                     CH_BACKSLASH: esc_char = CH_BACKSLASH;
                     default:      esc_known = 1'b0;
                  endcase
                  if (esc_known) begin
                     r.text_valid = 1'b1;
                     r.text_byte = esc_char;
                  end else begin
                     r.kind = KIND_NONE;
                     error_r = ERR_ESCAPE;
                     mode_r = MODE_IDLE;
                  end
               end else if (c == CH_BACKSLASH) begin
                  escape_r = 1'b1;
               end else begin
                  r.text_valid = 1'b1;
                  r.text_byte = c;
                  if (c == CH_QUOTE) begin
                     r.tok_end = 1'b1;
                     mode_r = MODE_IDLE;
                  end
               end
            end
            default: scan_idle = 1'b1;
         endcase

         // Between tokens: separators, single-byte tokens and token openers.
         if (scan_idle) begin
            case (c)
               CH_SPACE, CH_TAB: ;
               CH_NEWLINE: begin
                  if (lines_r != 16'hFFFF) lines_r = lines_r + 16'd1;
               end
               CH_COMMA:    r.kind = KIND_COMMA;
               CH_COLON:    r.kind = KIND_COLON;
               CH_LBRACKET: r.kind = KIND_LBRACKET;
               CH_RBRACKET: r.kind = KIND_RBRACKET;
               CH_QUOTE: begin
                  r.kind = KIND_STRING;
                  mode_r = MODE_STR;
                  escape_r = 1'b0;
               end
               default: begin
                  if (dec_digit(c)) begin
                     r.kind = KIND_NUMBER;
                     mode_r = MODE_NUM;
                  end else if (alpha_char(c) || c == CH_UNDERSCORE) begin
                     r.kind = KIND_IDENT;
                     mode_r = MODE_IDENT;
                  end else begin
                     error_r = ERR_UNEXPECTED;
                  end
               end
            endcase
            if (r.kind != KIND_NONE) begin
               r.start = 1'b1;
               r.text_valid = 1'b1;
               r.text_byte = c;
               r.tok_end = (mode_r == MODE_IDLE);
            end
         end

         // A fresh error blanks the token fields; an open token closes at end of text.
         if (error_r != ERR_NONE) begin
            r.kind = KIND_NONE;
            r.start = 1'b0;
            r.tok_end = 1'b0;
            r.text_valid = 1'b0;
            r.text_byte = '0;
            mode_r = MODE_IDLE;
            escape_r = 1'b0;
         end else if (last && mode_r != MODE_IDLE) begin
            r.tok_end = 1'b1;
         end
      end

      r.line = lines_r;
      r.err = error_r;
      r.done = last;
      if (last) begin
         mode_r = MODE_IDLE;
         escape_r = 1'b0;
         lines_r = '0;
         error_r = ERR_NONE;
      end
      return r;
   endfunction

   // Responses are checked before the request of the same edge is predicted.
   always @(posedge clock) begin
      lex_token_type seen;
      lex_token_type want;
      if (reset) begin
         mode_r = MODE_IDLE;
         escape_r = 1'b0;
         lines_r = '0;
         error_r = ERR_NONE;
         token_q.delete();
         lexed_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            seen = {rsp_token_kind, rsp_token_start, rsp_token_end, rsp_prev_closed,
                    rsp_text_valid, rsp_text_byte, rsp_line_number, rsp_error_code,
                    rsp_text_done};
            if (token_q.size() == 0) begin
               mismatch_count = mismatch_count + 1;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("%0t: response with none expected: %s", $realtime, describe(seen));
            end else begin
               want = token_q.pop_front();
               if (seen !== want) begin
                  mismatch_count = mismatch_count + 1;
                  if (mismatch_count <= REPORT_LIMIT) begin
                     $display("%0t: response mismatch", $realtime);
                     $display("   expected %s", describe(want));
                     $display("   actual   %s", describe(seen));
                  end
               end
            end
         end
         if (req_valid && !req_stall) begin
            if (error_r == ERR_NONE) lexed_count = lexed_count + 1;
            token_q.insert(token_q.size(), lex_byte(req_char_byte, req_last_byte));
         end
      end
      pending_count = token_q.size();
   end

endmodule

// ----- dv/tb_top.sv -----
// Top of the assembly token lexer testbench: clock, reset, request stimulus and verdict.
// Instantiates assembly_token_lexer and lexer_checker; uses atl_pkg for character codes.
module tb_top;
   import atl_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS   = 1100;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 10;

   typedef logic [7:0] byte_q_type[$];

   typedef enum int {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_mode_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_char_byte;
   logic        req_last_byte;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_token_kind;
   logic        rsp_token_start;
   logic        rsp_token_end;
   logic        rsp_prev_closed;
   logic        rsp_text_valid;
   logic [7:0]  rsp_text_byte;
   logic [15:0] rsp_line_number;
   logic [1:0]  rsp_error_code;
   logic        rsp_text_done;
   int          mismatch_count;
   int          pending_count;
   int          lexed_count;

   int             burst_left;
   int             stall_left;
   int             stall_tick;
   stall_mode_type stall_mode;
   int             idle_cycles;

   assembly_token_lexer dut (.*);
   lexer_checker lex_chk (.*);

   // 10 ns clock.
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // The receiver switches among stall patterns of random duration.
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(STALL_NONE, STALL_PERIODIC));
         stall_left = $urandom_range(16, 160);
      end
      stall_left = stall_left - 1;
      stall_tick = stall_tick + 1;
      case (stall_mode)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
         default:     rsp_stall <= (stall_tick % 5) < 2;
      endcase
   end

   // Ends the run when neither channel moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles = idle_cycles + 1;
         if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // Offers one request and holds it until accepted. Bursts alternate with gaps.
   task automatic send_byte(input logic [7:0] c, input logic last);
      int gap;
      if (burst_left == 0) begin
         if ($urandom_range(0, 7) == 0) begin
            burst_left = $urandom_range(100, 300);
            gap = 0;
         end else begin
            burst_left = $urandom_range(1, 30);
            gap = $urandom_range(0, 8);
         end
         repeat (gap) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
      end
      burst_left = burst_left - 1;
      req_valid <= 1'b1;
      req_char_byte <= c;
      req_last_byte <= last;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic send_text(ref byte_q_type txt);
      foreach (txt[i]) send_byte(txt[i], i == txt.size() - 1);
   endtask

   // Holds off new requests until every predicted response has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   // Adds one byte at the end of a text.
   function automatic void append_byte(ref byte_q_type txt, input logic [7:0] c);
      txt.insert(txt.size(), c);
   endfunction

   function automatic logic [7:0] ident_char(input logic lead);
      case ($urandom_range(0, lead ? 5 : 7))
         0, 1, 2: return 8'(CH_LOWER_A + $urandom_range(0, 25));
         3, 4:    return 8'(CH_UPPER_A + $urandom_range(0, 25));
         5:       return CH_UNDERSCORE;
         6:       return 8'(CH_DIGIT_0 + $urandom_range(0, 9));
         default: return CH_HYPHEN;
      endcase
   endfunction

   // Mostly well-formed token streams with random content; some noise texts,
   // stray bytes, bad escapes and unterminated strings.
   task automatic build_text(ref byte_q_type txt);
      logic [7:0] c;
      txt.delete();
      if ($urandom_range(0, 99) < 8) begin
         repeat ($urandom_range(1, 12)) append_byte(txt, 8'($urandom_range(0, 255)));
         return;
      end
      repeat ($urandom_range(1, 8)) begin
         repeat ($urandom_range(0, 2)) begin
            case ($urandom_range(0, 3))
               0:       append_byte(txt, CH_SPACE);
               1:       append_byte(txt, CH_TAB);
               default: append_byte(txt, CH_NEWLINE);
            endcase
         end
         if ($urandom_range(0, 39) == 0) append_byte(txt, 8'($urandom_range(0, 255)));
         case ($urandom_range(0, 6))
            0: append_byte(txt, CH_COMMA);
            1: append_byte(txt, CH_COLON);
            2: append_byte(txt, CH_LBRACKET);
            3: append_byte(txt, CH_RBRACKET);
            4: repeat ($urandom_range(1, 6))
                  append_byte(txt, 8'(CH_DIGIT_0 + $urandom_range(0, 9)));
            5: begin
               append_byte(txt, ident_char(1'b1));
               repeat ($urandom_range(0, 7)) append_byte(txt, ident_char(1'b0));
            end
            default: begin
               append_byte(txt, CH_QUOTE);
               repeat ($urandom_range(0, 8)) begin
                  if ($urandom_range(0, 3) == 0) begin
                     append_byte(txt, CH_BACKSLASH);
                     case ($urandom_range(0, 15))
                        0, 7:    append_byte(txt, CH_LOWER_N);
                        1, 8:    append_byte(txt, CH_LOWER_T);
                        2, 9:    append_byte(txt, CH_LOWER_R);
                        3, 10:   append_byte(txt, CH_LOWER_A);
                        4, 11:   append_byte(txt, CH_DIGIT_0);
                        5, 12:   append_byte(txt, CH_QUOTE);
                        6, 13:   append_byte(txt, CH_BACKSLASH);
                        14:      append_byte(txt, CH_LOWER_N);
                        default: append_byte(txt, 8'($urandom_range(0, 255)));
                     endcase
                  end else begin
                     do c = 8'($urandom_range(0, 255));
                     while (c == CH_QUOTE || c == CH_BACKSLASH);
                     append_byte(txt, c);
                  end
               end
               // Usually closed; otherwise the string runs on, maybe with a dangling escape.
               if ($urandom_range(0, 9) != 0) append_byte(txt, CH_QUOTE);
               else if ($urandom_range(0, 1) == 0) append_byte(txt, CH_BACKSLASH);
            end
         endcase
      end
   endtask

   initial begin
      byte_q_type txt;
      int         lexed_base;
      int         text_count;
      reset = 1'b1;
      req_valid = 1'b0;
      req_char_byte = '0;
      req_last_byte = 1'b0;
      burst_left = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Line counted before tokens; every punctuation kind; an identifier with
      // underscore, hyphen and digit closed by a comma; a number closed by a
      // bracket; a number left open at the end of the text.
      txt = '{CH_NEWLINE, CH_LBRACKET, CH_UNDERSCORE, CH_UPPER_Z, CH_HYPHEN, CH_DIGIT_9,
              CH_COMMA, CH_DIGIT_0, CH_RBRACKET, CH_COLON, CH_DIGIT_9};
      send_text(txt);
      // Every escape, in a string that is never closed.
      txt = '{CH_QUOTE, CH_BACKSLASH, CH_LOWER_N, CH_BACKSLASH, CH_LOWER_T,
              CH_BACKSLASH, CH_LOWER_R, CH_BACKSLASH, CH_LOWER_A, CH_BACKSLASH, CH_DIGIT_0,
              CH_BACKSLASH, CH_QUOTE, CH_BACKSLASH, CH_BACKSLASH};
      send_text(txt);
      // An unexpected byte right after a number, then a byte that is ignored.
      txt = '{CH_DIGIT_0, 8'hFF, CH_LBRACKET};
      send_text(txt);
      // An unknown escape ends the text.
      txt = '{CH_QUOTE, CH_BACKSLASH, CH_LOWER_Z};
      send_text(txt);
      wait_drained();

      // Random token streams.
      lexed_base = lexed_count;
      text_count = 0;
      while (lexed_count - lexed_base < RANDOM_ITEMS) begin
         build_text(txt);
         send_text(txt);
         text_count = text_count + 1;
         if (text_count % 16 == 0 && $urandom_range(0, 1) == 0) wait_drained();
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
hw/rtl/atl_pkg.sv
hw/rtl/atl_front.sv
hw/rtl/atl_queue.sv
hw/rtl/atl_back.sv
hw/rtl/assembly_token_lexer.sv
hw/rtl/atl_checker.sv
dv/lexer_checker.sv
dv/tb_top.sv
